// ===== rtl/core/bfha_pkg.sv =====
`default_nettype none
package bfha_pkg;

    localparam logic [7:0] END_ID  = 8'hFF;
    localparam logic [7:0] FREE_ID = 8'h00;
    localparam logic [7:0] ID_SKIP = 8'hFE;
    localparam logic [3:0] HDR_OFS = 4'hD;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [0:0] CFG_HEAP_START = 1'b0;
    localparam logic [0:0] CFG_HEAP_END   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_bytes;
        logic [15:0] block_address;
    } bfha_in_t;

    typedef struct packed {
        logic [15:0] payload_address;
        logic        granted;
    } bfha_out_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] size;
    } bfha_hdr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD_CUR,
        ST_WAIT_CUR,
        ST_RD_NXT,
        ST_WAIT_NXT,
        ST_DECIDE,
        ST_TAG,
        ST_SPLIT,
        ST_SHRINK,
        ST_RD_FREE,
        ST_OUT
    } bfha_state_t;

    // Round an address up to the next header slot (offset 13 of a paragraph).
    function automatic logic [15:0] align_hdr(input logic [15:0] a);
        logic [15:0] r;
        if (a[3:0] <= HDR_OFS) begin
            r = {a[15:4], HDR_OFS};
        end else begin
            r = {a[15:4] + 12'd1, HDR_OFS};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/best_fit_heap_allocator_top.sv =====
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | bfha_in_t (opcode, request_bytes, block_address)
// m_       | out       | m_valid / m_ready  | bfha_out_t (payload_address, granted)
// cfg_     | in        | cfg_we             | cfg_index, cfg_data
//
// A free is accepted, reads the header and, if the address is a header, writes it back with the id cleared.
// An allocate is accepted, builds the heap on the first one, reads each used header,
// reads each free header and the one after it to merge or weigh it, stops at the end
// marker, then tags, splits and loads the result; each read waits on the registered memory.
// Reset clears control state only; the header memory is undefined until built.
// A new result waits in the last state only while the previous one is unaccepted.
`default_nettype none
module best_fit_heap_allocator_top #(
    parameter int PARAGRAPHS      = 4096,
    parameter int SPLIT_MIN_BYTES = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bfha_pkg::bfha_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bfha_pkg::bfha_out_t      m_data,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import bfha_pkg::*;

    localparam int AW        = $clog2(PARAGRAPHS);
    localparam int WALK_STEPS = 2 * PARAGRAPHS + 2;
    localparam int SW        = $clog2(WALK_STEPS + 1);

    // Header memory: one port, registered read
    bfha_hdr_t mem [PARAGRAPHS];
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    bfha_hdr_t     mem_wdata;
    bfha_hdr_t     mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    function automatic logic [AW-1:0] slot(input logic [15:0] a);
        logic [11:0] p;
        p = a[15:4];
        return p[AW-1:0];
    endfunction

    bfha_state_t state_reg, state_next;
    logic [15:0] heap_start_reg, heap_end_reg;
    logic        ready_reg;
    logic [7:0]  idc_reg;
    bfha_in_t    req_reg;
    logic [15:0] addr_reg, addr_next;
    bfha_hdr_t   cur_reg;
    logic [15:0] nx_reg;
    logic [15:0] best_addr_reg, best_size_reg;
    logic        found_reg;
    logic [SW-1:0] steps_reg;
    logic        init_ph_reg;
    logic [15:0] nh_reg, room_reg;
    logic        out_valid_reg;
    bfha_out_t   out_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg <= '0;
            heap_end_reg   <= 16'hFFFF;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HEAP_START: heap_start_reg <= cfg_data;
                CFG_HEAP_END:   heap_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0] free_h;
    logic        free_ok;
    logic        walk_done;
    logic [15:0] nx_calc;
    logic [15:0] next_walk;
    logic [7:0]  id_new;
    logic [7:0]  idc_next;
    logic [15:0] nh_calc, xh_calc;
    logic        out_stall;

    assign free_h    = req_reg.block_address - 16'd3;
    assign free_ok   = (req_reg.block_address != 16'd0) && (free_h[3:0] == HDR_OFS);
    assign walk_done = (steps_reg == SW'(WALK_STEPS));
    assign nx_calc   = align_hdr(addr_reg + mem_rdata.size + 16'd3);
    assign next_walk = addr_reg + cur_reg.size + 16'd3;
    assign id_new    = idc_reg + 8'd1;
    assign idc_next  = (id_new == ID_SKIP) ? id_new + 8'd2 : id_new;
    assign nh_calc   = align_hdr(best_addr_reg + 16'd3 + req_reg.request_bytes);
    assign xh_calc   = align_hdr(best_addr_reg + 16'd3 + best_size_reg);
    // Hold a new result while the previous one still waits on the output
    assign out_stall = (req_reg.opcode == OP_ALLOC) && out_valid_reg && !m_ready;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.opcode == OP_FREE) state_next = ST_RD_FREE;
                    else if (!ready_reg) state_next = ST_INIT;
                    else state_next = ST_RD_CUR;
                end
            end
            ST_INIT:     state_next = init_ph_reg ? ST_RD_CUR : ST_INIT;
            ST_RD_CUR:   state_next = walk_done ? ST_TAG : ST_WAIT_CUR;
            ST_WAIT_CUR: begin
                if (mem_rdata.id == END_ID) state_next = ST_TAG;
                else if (mem_rdata.id == FREE_ID) state_next = ST_RD_NXT;
                else state_next = ST_RD_CUR;
            end
            ST_RD_NXT:   state_next = ST_WAIT_NXT;
            ST_WAIT_NXT: state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_RD_CUR;
            ST_TAG:      state_next = found_reg ? ST_SPLIT : ST_OUT;
            ST_SPLIT: begin
                if (room_reg >= 16'(SPLIT_MIN_BYTES)) state_next = ST_SHRINK;
                else state_next = ST_OUT;
            end
            ST_SHRINK:   state_next = ST_OUT;
            ST_RD_FREE:  state_next = ST_OUT;
            ST_OUT:      state_next = out_stall ? ST_OUT : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = slot(addr_reg);
        mem_wdata = '0;
        case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                if (!init_ph_reg) begin
                    mem_addr  = slot(align_hdr(heap_end_reg));
                    mem_wdata = '{id: END_ID, size: 16'd0};
                end else begin
                    mem_addr  = slot(align_hdr(heap_start_reg));
                    mem_wdata = '{id: FREE_ID,
                        size: heap_end_reg - (align_hdr(heap_start_reg) + 16'd3)};
                end
            end
            ST_RD_CUR: mem_addr = slot(align_hdr(addr_reg));
            ST_RD_NXT: mem_addr = slot(nx_reg);
            ST_WAIT_NXT: mem_addr = slot(nx_reg);
            ST_DECIDE: begin
                mem_addr = slot(addr_reg);
                if (mem_rdata.size != 16'd0 && mem_rdata.id == FREE_ID) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{id: FREE_ID,
                        size: cur_reg.size + mem_rdata.size + 16'd3};
                end
            end
            ST_TAG: begin
                mem_addr  = slot(best_addr_reg);
                mem_we    = found_reg;
                mem_wdata = '{id: id_new, size: best_size_reg};
            end
            ST_SPLIT: begin
                mem_addr  = slot(nh_reg);
                mem_we    = room_reg >= 16'(SPLIT_MIN_BYTES);
                mem_wdata = '{id: FREE_ID, size: room_reg - 16'd3};
            end
            ST_SHRINK: begin
                mem_addr  = slot(best_addr_reg);
                mem_we    = 1'b1;
                mem_wdata = '{id: id_new, size: nh_reg - best_addr_reg - 16'd3};
            end
            ST_RD_FREE: mem_addr = slot(free_h);
            ST_OUT: begin
                mem_addr  = slot(free_h);
                mem_we    = (req_reg.opcode == OP_FREE) && free_ok;
                mem_wdata = '{id: FREE_ID, size: mem_rdata.size};
            end
            default: ;
        endcase
    end

    // Walk pointer
    always_comb begin
        addr_next = addr_reg;
        case (state_reg)
            ST_IDLE:     addr_next = heap_start_reg;
            ST_RD_CUR:   addr_next = align_hdr(addr_reg);
            ST_WAIT_CUR: if (mem_rdata.id != FREE_ID) addr_next = addr_reg + mem_rdata.size + 16'd3;
            ST_DECIDE: begin
                if (!(mem_rdata.size != 16'd0 && mem_rdata.id == FREE_ID)) begin
                    addr_next = next_walk;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            idc_reg       <= '0;
            out_valid_reg <= 1'b0;
            init_ph_reg   <= 1'b0;
            found_reg     <= 1'b0;
            steps_reg     <= '0;
        end else begin
            state_reg <= state_next;
            // Load a new result or drop the accepted one
            if (state_reg == ST_OUT && req_reg.opcode == OP_ALLOC && !out_stall) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    found_reg   <= 1'b0;
                    steps_reg   <= '0;
                    init_ph_reg <= 1'b0;
                end
                ST_INIT: begin
                    init_ph_reg <= 1'b1;
                    ready_reg   <= 1'b1;
                end
                ST_RD_CUR: if (!walk_done) steps_reg <= steps_reg + SW'(1);
                ST_DECIDE: begin
                    if (!(mem_rdata.size != 16'd0 && mem_rdata.id == FREE_ID) &&
                        cur_reg.size >= req_reg.request_bytes &&
                        (!found_reg || best_size_reg > cur_reg.size)) begin
                        found_reg <= 1'b1;
                    end
                end
                ST_OUT: if (found_reg && !out_stall) idc_reg <= idc_next;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) req_reg <= s_data;
            end
            ST_WAIT_CUR: begin
                cur_reg <= mem_rdata;
                nx_reg  <= nx_calc;
            end
            ST_DECIDE: begin
                if (!(mem_rdata.size != 16'd0 && mem_rdata.id == FREE_ID) &&
                    cur_reg.size >= req_reg.request_bytes &&
                    (!found_reg || best_size_reg > cur_reg.size)) begin
                    best_addr_reg <= addr_reg;
                    best_size_reg <= cur_reg.size;
                end
                if (mem_rdata.size != 16'd0 && mem_rdata.id == FREE_ID) begin
                    cur_reg.size <= cur_reg.size + mem_rdata.size + 16'd3;
                end
            end
            ST_TAG: begin
                nh_reg   <= nh_calc;
                room_reg <= xh_calc - nh_calc;
            end
            ST_OUT: begin
                if (req_reg.opcode == OP_ALLOC && !out_stall) begin
                    out_reg.granted         <= found_reg;
                    out_reg.payload_address <= found_reg ? best_addr_reg + 16'd3 : 16'd0;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_grant_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.granted) |-> (m_data.payload_address == 16'd0))
        else $error("failed allocate with address");
    a_grant_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.granted) |-> (m_data.payload_address[3:0] == 4'h0))
        else $error("payload misaligned");
    a_id_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (idc_reg != END_ID) && (idc_reg != ID_SKIP)) else $error("bad id counter");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_best_fit_heap_allocator_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_best_fit_heap_allocator_top;
    import bfha_pkg::*;

    localparam int PARAS      = 4096;
    localparam int SPLIT_MIN  = 32;
    localparam int WALK_LIMIT = 2 * PARAS + 2;
    localparam int MAX_CYCLES = 10_000_000;
    localparam int RAND_ITEMS = 1400;

    typedef struct {
        bfha_in_t  item;
        bit        typed;
        bfha_out_t want;
    } plan_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    bfha_in_t    s_data  = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    bfha_out_t   m_data;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = CFG_HEAP_START;
    logic [15:0] cfg_data  = '0;

    // Predicted heap state
    logic [7:0]  hdr_id   [PARAS];
    logic [15:0] hdr_size [PARAS];
    bit          heap_built = 1'b0;
    logic [7:0]  id_roll    = 8'd0;
    logic [15:0] walk_start = 16'h0000;
    logic [15:0] heap_limit = 16'hFFFF;

    bfha_out_t   grant_q [$];
    logic [15:0] live_blocks [$];
    plan_row_t   plan [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;

    always #10 aclk = ~aclk;

    best_fit_heap_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Round up to the next header slot, offset 13 of a paragraph
    function automatic logic [15:0] slot_up(input logic [15:0] a);
        logic [15:0] t;
        t = (a + 16'd2) | 16'h000F;
        return t - 16'd2;
    endfunction

    // Predict one transaction and advance the heap state
    task automatic heap_step(input bfha_in_t t, output bit has_res, output bfha_out_t res);
        logic [15:0] a, h, e, f, sz, nx, nsz, best_a, best_sz, nh, xh, room;
        logic [7:0]  id;
        bit          found;
        int          n;
        has_res = 1'b0;
        res = '0;
        if (t.opcode == OP_FREE) begin
            h = t.block_address - 16'd3;
            if (t.block_address != 16'd0 && h[3:0] == HDR_OFS)
                hdr_id[h[15:4]] = FREE_ID;
            return;
        end
        has_res = 1'b1;
        if (!heap_built) begin
            e = slot_up(heap_limit);
            f = slot_up(walk_start);
            heap_built = 1'b1;
            hdr_id[e[15:4]] = END_ID;
            hdr_size[e[15:4]] = 16'd0;
            hdr_id[f[15:4]] = FREE_ID;
            hdr_size[f[15:4]] = heap_limit - (f + 16'd3);
        end
        a = walk_start;
        found = 1'b0;
        best_a = '0;
        best_sz = '0;
        for (n = 0; n < WALK_LIMIT; n++) begin
            a = slot_up(a);
            id = hdr_id[a[15:4]];
            sz = hdr_size[a[15:4]];
            if (id == END_ID) break;
            if (id == FREE_ID) begin
                nx = slot_up(a + sz + 16'd3);
                nsz = hdr_size[nx[15:4]];
                // merge with a free neighbour and revisit the same header
                if (nsz != 16'd0 && hdr_id[nx[15:4]] == FREE_ID) begin
                    hdr_size[a[15:4]] = sz + nsz + 16'd3;
                    continue;
                end
                if (sz >= t.request_bytes && (!found || best_sz > sz)) begin
                    found = 1'b1;
                    best_a = a;
                    best_sz = sz;
                end
            end
            a = a + sz + 16'd3;
        end
        if (!found) return;
        id_roll = id_roll + 8'd1;
        hdr_id[best_a[15:4]] = id_roll;
        if (id_roll == ID_SKIP) id_roll = id_roll + 8'd2;
        nh = slot_up(best_a + 16'd3 + t.request_bytes);
        xh = slot_up(best_a + 16'd3 + best_sz);
        room = xh - nh;
        // split off the tail when enough room remains
        if (room >= 16'(SPLIT_MIN)) begin
            hdr_id[nh[15:4]] = FREE_ID;
            hdr_size[nh[15:4]] = room - 16'd3;
            hdr_size[best_a[15:4]] = nh - best_a - 16'd3;
        end
        res.payload_address = best_a + 16'd3;
        res.granted = 1'b1;
    endtask

    function automatic plan_row_t mk_row(input logic op, input logic [15:0] bytes,
                                         input logic [15:0] addr, input bit typed,
                                         input logic [15:0] pa, input logic g);
        plan_row_t r;
        r.item.opcode = op;
        r.item.request_bytes = bytes;
        r.item.block_address = addr;
        r.typed = typed;
        r.want.payload_address = pa;
        r.want.granted = g;
        return r;
    endfunction

    // Mostly well-formed allocate/free traffic, some noise
    function automatic bfha_in_t pick_item();
        bfha_in_t t;
        int k, j;
        t.opcode = OP_ALLOC;
        t.request_bytes = 16'($urandom_range(0, 96));
        t.block_address = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 55) begin
            j = $urandom_range(0, 99);
            if (j < 10) t.request_bytes = 16'($urandom_range(0, 16'h03F0));
            else if (j < 15) t.request_bytes = 16'($urandom);
        end else if (k < 85) begin
            t.opcode = OP_FREE;
            t.block_address = 16'd0;
            if (live_blocks.size() > 0) begin
                j = $urandom_range(0, live_blocks.size() - 1);
                t.block_address = live_blocks[j];
                live_blocks.delete(j);
            end
        end else if (k < 90) begin
            t.opcode = OP_FREE;
            t.block_address = 16'd0;
        end else begin
            // free of an address that is not a header
            t.opcode = OP_FREE;
            if (((t.block_address - 16'd3) & 16'h000F) == {12'd0, HDR_OFS})
                t.block_address = t.block_address ^ 16'h0001;
        end
        return t;
    endfunction

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one transaction, hold it until accepted, then predict
    task automatic send(input bfha_in_t t, input bit typed, input bfha_out_t want);
        bit        has_res;
        bfha_out_t res;
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        heap_step(t, has_res, res);
        if (has_res) begin
            grant_q.push_back(typed ? want : res);
            if (res.granted) live_blocks.push_back(res.payload_address);
        end
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        if (idx == CFG_HEAP_START) walk_start = val;
        else heap_limit = val;
    endtask

    // Hold off until every result has arrived and any trailing free is done
    task automatic drain();
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Check results against the oldest prediction
    always @(posedge aclk) begin
        bfha_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                note_fail($sformatf("unexpected result addr=%h granted=%b",
                                    m_data.payload_address, m_data.granted));
            end else begin
                exp_r = grant_q.pop_front();
                if (m_data.payload_address !== exp_r.payload_address)
                    note_fail($sformatf("payload_address exp=%h got=%h",
                                        exp_r.payload_address, m_data.payload_address));
                if (m_data.granted !== exp_r.granted)
                    note_fail($sformatf("granted exp=%b got=%b",
                                        exp_r.granted, m_data.granted));
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("best_fit_heap_allocator_top test failed");
            $finish;
        end
    end

    initial begin
        int i;
        bfha_out_t none;
        none = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sweep register extremes, then settle on a 1 KB heap at address 0
        cfg_write(CFG_HEAP_START, 16'hFFFF);
        cfg_write(CFG_HEAP_END, 16'h0000);
        cfg_write(CFG_HEAP_START, 16'h0000);
        cfg_write(CFG_HEAP_END, 16'h0400);
        cfg_we <= 1'b0;
        @(posedge aclk);

        // free before build
        plan.push_back(mk_row(OP_FREE, 16'd0, 16'h0010, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'd16, 16'h0000, 1'b1, 16'h0010, 1'b1));
        plan.push_back(mk_row(OP_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'd0, 16'h0000, 1'b1, 16'h0030, 1'b1));
        // null free
        plan.push_back(mk_row(OP_FREE, 16'hFFFF, 16'd0, 1'b0, 16'h0000, 1'b0));
        // not a header
        plan.push_back(mk_row(OP_FREE, 16'd0, 16'h1234, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_FREE, 16'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'h8000, 16'd0, 1'b1, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'd100, 16'd0, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_FREE, 16'd0, 16'h0010, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_FREE, 16'd0, 16'h0030, 1'b0, 16'h0000, 1'b0));
        // merged fit
        plan.push_back(mk_row(OP_ALLOC, 16'd13, 16'd0, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'd29, 16'd0, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'd1, 16'd0, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'h0300, 16'd0, 1'b0, 16'h0000, 1'b0));
        plan.push_back(mk_row(OP_ALLOC, 16'h0300, 16'd0, 1'b0, 16'h0000, 1'b0));
        foreach (plan[k]) send(plan[k].item, plan[k].typed, plan[k].want);

        for (i = 0; i < RAND_ITEMS / 3; i++) send(pick_item(), 1'b0, none);

        // Hold the sender until all results are in, then move the walk start
        drain();
        cfg_write(CFG_HEAP_START, 16'h0007);
        cfg_write(CFG_HEAP_END, 16'hFFFF);
        cfg_we <= 1'b0;
        @(posedge aclk);
        calm = 1'b1;
        for (i = 0; i < RAND_ITEMS / 3; i++) begin
            if (i == 150) calm = 1'b0;
            send(pick_item(), 1'b0, none);
        end

        drain();
        cfg_write(CFG_HEAP_START, 16'h000D);
        cfg_write(CFG_HEAP_END, 16'h0000);
        cfg_we <= 1'b0;
        @(posedge aclk);
        for (i = 0; i < RAND_ITEMS / 3; i++) send(pick_item(), 1'b0, none);

        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("best_fit_heap_allocator_top test passed");
        end else begin
            $display("best_fit_heap_allocator_top test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
